@@ rtl/circular_deque_macros.svh @@
// assertion macros for the circular deque
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge outside reset
`define CD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("circular_deque: invariant violated");
// consequent holds in the cycle after the antecedent
`define CD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("circular_deque: sequence violated");
`else
`define CD_ASSERT_ALWAYS(lbl, cond)
`define CD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/cd_pkg.sv @@
package cd_pkg;

  localparam int WORD_W = 32;
  localparam int CAP_W  = 4;
  localparam int CMD_W  = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET   = 4'd15;
  localparam logic [WORD_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_NOP        = 3'd4
  } cmd_e;

  // per-cycle operation broadcast to every cell
  typedef struct packed {
    logic clear;        // drop all entries
    logic shift_back;   // push front: entries move one cell toward the rear
    logic shift_fwd;    // pop front: entries move one cell toward the front
    logic append_rear;  // push rear: first free cell takes the word
    logic drop_rear;    // pop rear: last occupied cell frees itself
  } cell_op_t;

endpackage

@@ rtl/cd_cell.sv @@
module cd_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cd_pkg::cell_op_t           op_i,
  input  logic [cd_pkg::WORD_W-1:0]  push_val_i,
  input  logic [cd_pkg::WORD_W-1:0]  left_val_i,
  input  logic                       left_occ_i,
  input  logic [cd_pkg::WORD_W-1:0]  right_val_i,
  input  logic                       right_occ_i,
  output logic [cd_pkg::WORD_W-1:0]  val_o,
  output logic                       occ_o,
  output logic [cd_pkg::WORD_W-1:0]  rear_tap_o
);

  logic [cd_pkg::WORD_W-1:0] val_q, val_d;
  logic                      occ_q, occ_d;
  logic                      is_last;

  // this cell holds the rear entry when its right neighbor is free
  assign is_last = occ_q & ~right_occ_i;

  // next cell contents from the broadcast operation and neighbors
  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (op_i.clear) begin
      occ_d = 1'b0;
    end else if (op_i.shift_back) begin
      val_d = left_val_i;
      occ_d = left_occ_i;
    end else if (op_i.shift_fwd) begin
      val_d = right_val_i;
      occ_d = right_occ_i;
    end else if (op_i.append_rear) begin
      // first free cell behind the occupied run takes the pushed word
      if (!occ_q && left_occ_i) begin
        val_d = push_val_i;
        occ_d = 1'b1;
      end
    end else if (op_i.drop_rear) begin
      if (is_last) begin
        occ_d = 1'b0;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // stored word
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o      = val_q;
  assign occ_o      = occ_q;
  assign rear_tap_o = is_last ? val_q : '0;

endmodule

@@ rtl/circular_deque.sv @@
// circular_deque: double-ended queue built as a row of shifting cells.
// An accepted command word is held pending while the cell row updates; its result word is formed
// from the updated cell row and loaded once the output register is free to take it. No new command
// word is accepted while one is pending or while the output register is held by a stall.
// Reset: capacity returns to 15, the deque is empty, and no result is pending;
// cell contents stay undefined until pushed.
module circular_deque #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       capacity_we_i,
  input  logic [cd_pkg::CAP_W-1:0]   capacity_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [cd_pkg::CMD_W-1:0]   command_i,
  input  logic [cd_pkg::WORD_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic                       empty_res_o,
  output logic                       full_res_o,
  output logic [cd_pkg::WORD_W-1:0]  front_value_o,
  output logic [cd_pkg::WORD_W-1:0]  rear_value_o
);

  localparam int NCELL = SLOT_COUNT - 1;
  localparam int CW    = $clog2(SLOT_COUNT);
  localparam int MW    = (CW > cd_pkg::CAP_W) ? CW : cd_pkg::CAP_W;
  localparam logic [MW-1:0] CAP_MAX = MW'(SLOT_COUNT - 1);

  logic [cd_pkg::CAP_W-1:0] capacity_q;
  logic [CW-1:0]            count_q, count_d;
  logic [MW-1:0]            cap_ext;
  logic [CW-1:0]            cap_eff;
  logic                     empty, full;
  logic                     in_acc, out_free, load;
  logic                     pend_q, ok_q, ok_d;
  logic                     out_valid_q, ok_out_q, empty_out_q, full_out_q;
  logic [cd_pkg::WORD_W-1:0] front_q, rear_q, rear_or;
  cd_pkg::cmd_e             cmd;
  cd_pkg::cell_op_t         op;

  logic [cd_pkg::WORD_W-1:0] cell_val [NCELL];
  logic [cd_pkg::WORD_W-1:0] rear_tap [NCELL];
  logic [NCELL-1:0]          cell_occ;

  // capacity saturated to the number of cells
  assign cap_ext = MW'(capacity_q);
  assign cap_eff = CW'((cap_ext > CAP_MAX) ? CAP_MAX : cap_ext);
  assign empty   = (count_q == '0);
  assign full    = (count_q == cap_eff);

  // handshake
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = pend_q | ~out_free;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign load       = pend_q & out_free;
  assign cmd        = cd_pkg::cmd_e'(command_i);

  // command decode
  always_comb begin
    op      = '0;
    ok_d    = 1'b1;
    count_d = count_q;
    op.clear = capacity_we_i;
    if (capacity_we_i) begin
      count_d = '0;
    end else if (in_acc) begin
      unique case (cmd)
        cd_pkg::CMD_PUSH_FRONT: begin
          ok_d = ~full;
          op.shift_back = ~full;
          if (!full) count_d = count_q + CW'(1);
        end
        cd_pkg::CMD_PUSH_REAR: begin
          ok_d = ~full;
          op.append_rear = ~full;
          if (!full) count_d = count_q + CW'(1);
        end
        cd_pkg::CMD_POP_FRONT: begin
          ok_d = ~empty;
          op.shift_fwd = ~empty;
          if (!empty) count_d = count_q - CW'(1);
        end
        cd_pkg::CMD_POP_REAR: begin
          ok_d = ~empty;
          op.drop_rear = ~empty;
          if (!empty) count_d = count_q - CW'(1);
        end
        default: begin
          ok_d = 1'b1;
        end
      endcase
    end
  end

  // cell row, front entry in cell zero
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [cd_pkg::WORD_W-1:0] lv, rv;
    logic                      lo, ro;
    if (i == 0) begin : g_first
      assign lv = value_i;
      assign lo = 1'b1;
    end else begin : g_mid
      assign lv = cell_val[i-1];
      assign lo = cell_occ[i-1];
    end
    if (i == NCELL - 1) begin : g_last
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_inner
      assign rv = cell_val[i+1];
      assign ro = cell_occ[i+1];
    end
    cd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .push_val_i  (value_i),
      .left_val_i  (lv),
      .left_occ_i  (lo),
      .right_val_i (rv),
      .right_occ_i (ro),
      .val_o       (cell_val[i]),
      .occ_o       (cell_occ[i]),
      .rear_tap_o  (rear_tap[i])
    );
  end

  // rear entry gathered from the one-hot last-cell taps
  always_comb begin
    rear_or = '0;
    for (int i = 0; i < NCELL; i++) begin
      rear_or = rear_or | rear_tap[i];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= cd_pkg::CAP_RESET;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (capacity_we_i) capacity_q <= capacity_i;
      count_q <= count_d;
      if (in_acc) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (in_acc) ok_q <= ok_d;
    if (load) begin
      ok_out_q    <= ok_q;
      empty_out_q <= empty;
      full_out_q  <= full;
      front_q     <= empty ? cd_pkg::EMPTY_VALUE : cell_val[0];
      rear_q      <= empty ? cd_pkg::EMPTY_VALUE : rear_or;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_out_q;
  assign empty_res_o   = empty_out_q;
  assign full_res_o    = full_out_q;
  assign front_value_o = front_q;
  assign rear_value_o  = rear_q;

  // assertions
  `include "circular_deque_macros.svh"

  `CD_ASSERT_ALWAYS(a_count_in_range, count_q <= cap_eff)
  `CD_ASSERT_ALWAYS(a_occ_matches_count, $countones(cell_occ) == int'(count_q))
  `CD_ASSERT_NEXT(a_accept_sets_pending, in_acc, pend_q)
  `CD_ASSERT_NEXT(a_refused_keeps_count, in_acc && !ok_d && !capacity_we_i, $stable(count_q))

endmodule

@@ bench/circular_deque_checker.sv @@
// watches both channels of the deque, predicts every result word and compares it
module circular_deque_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      capacity_we_i,
  input  logic [cd_pkg::CAP_W-1:0]  capacity_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_o,
  input  logic [cd_pkg::CMD_W-1:0]  command_i,
  input  logic [cd_pkg::WORD_W-1:0] value_i,
  input  logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  logic                      ok_o,
  input  logic                      empty_res_o,
  input  logic                      full_res_o,
  input  logic [cd_pkg::WORD_W-1:0] front_value_o,
  input  logic [cd_pkg::WORD_W-1:0] rear_value_o,
  output int                        fail_count_o,
  output int                        outstanding_o,
  output int                        results_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_SLOTS = 16;

  typedef struct {
    logic                      ok;
    logic                      empty;
    logic                      full;
    logic [cd_pkg::WORD_W-1:0] front;
    logic [cd_pkg::WORD_W-1:0] rear;
  } deque_status_t;

  // shadow copy of the ring
  logic [cd_pkg::WORD_W-1:0] ring_mem [RING_SLOTS];
  int unsigned               head_ptr;
  int unsigned               tail_ptr;
  logic [cd_pkg::CAP_W-1:0]  cap_reg;

  deque_status_t     pending_status [$];
  int                errors;
  int                results_checked;

  assign fail_count_o      = errors;
  assign results_checked_o = results_checked;

  function automatic int unsigned ring_len();
    return (cap_reg > RING_SLOTS - 1) ? RING_SLOTS : cap_reg + 1;
  endfunction

  // one command applied to the shadow ring, status after the step
  function automatic deque_status_t deque_step(logic [cd_pkg::CMD_W-1:0] cmd,
                                               logic [cd_pkg::WORD_W-1:0] word);
    int unsigned   m;
    logic          was_empty;
    logic          was_full;
    deque_status_t st;
    m = ring_len();
    was_empty = (head_ptr == tail_ptr);
    was_full  = (((tail_ptr + 1) % m) == head_ptr);
    st.ok = 1'b1;
    case (cmd)
      cd_pkg::CMD_PUSH_FRONT: begin
        if (was_full) begin
          st.ok = 1'b0;
        end else begin
          ring_mem[head_ptr] = word;
          head_ptr = (head_ptr + m - 1) % m;
        end
      end
      cd_pkg::CMD_PUSH_REAR: begin
        if (was_full) begin
          st.ok = 1'b0;
        end else begin
          tail_ptr = (tail_ptr + 1) % m;
          ring_mem[tail_ptr] = word;
        end
      end
      cd_pkg::CMD_POP_FRONT: begin
        if (was_empty) st.ok = 1'b0;
        else head_ptr = (head_ptr + 1) % m;
      end
      cd_pkg::CMD_POP_REAR: begin
        if (was_empty) st.ok = 1'b0;
        else tail_ptr = (tail_ptr + m - 1) % m;
      end
      // nop and the spare codes leave the ring alone
      default: ;
    endcase
    st.empty = (head_ptr == tail_ptr);
    st.full  = (((tail_ptr + 1) % m) == head_ptr);
    if (st.empty) begin
      st.front = cd_pkg::EMPTY_VALUE;
      st.rear  = cd_pkg::EMPTY_VALUE;
    end else begin
      st.front = ring_mem[(head_ptr + 1) % m];
      st.rear  = ring_mem[tail_ptr];
    end
    return st;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < 40) $display("%0t ns checker: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [cd_pkg::WORD_W-1:0] got,
                             logic [cd_pkg::WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // config writes, result compare, then prediction of the newly accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    deque_status_t want;
    if (!rst_ni) begin
      cap_reg         = cd_pkg::CAP_RESET;
      head_ptr        = 0;
      tail_ptr        = 0;
      errors          = 0;
      results_checked = 0;
      pending_status.delete();
      outstanding_o  <= 0;
    end else begin
      if (capacity_we_i) begin
        cap_reg  = capacity_i;
        head_ptr = 0;
        tail_ptr = 0;
      end
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (pending_status.size() == 0) begin
          report_mismatch("result word with no command word waiting");
        end else begin
          want = pending_status.pop_front();
          check_field("ok", ok_o, want.ok);
          check_field("empty", empty_res_o, want.empty);
          check_field("full", full_res_o, want.full);
          check_field("front", front_value_o, want.front);
          check_field("rear", rear_value_o, want.rear);
        end
      end
      if (in_valid_i && !in_stall_o)
        pending_status.push_back(deque_step(command_i, value_i));
      outstanding_o <= pending_status.size();
    end
  end

endmodule

@@ bench/circular_deque_tb.sv @@
module circular_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 135;
  localparam int MAX_GAP     = 60;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      capacity_we_i = 1'b0;
  logic [cd_pkg::CAP_W-1:0]  capacity_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [cd_pkg::CMD_W-1:0]  command_i = cd_pkg::CMD_NOP;
  logic [cd_pkg::WORD_W-1:0] value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      ok_o;
  logic                      empty_res_o;
  logic                      full_res_o;
  logic [cd_pkg::WORD_W-1:0] front_value_o;
  logic [cd_pkg::WORD_W-1:0] rear_value_o;

  int fail_count;
  int outstanding;
  int results_checked;

  // stimulus knobs and a rough occupancy guess to steer push versus pop
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_on = 1'b0;
  int unsigned cap_now = cd_pkg::CAP_RESET;
  int unsigned fill_level = 0;
  logic        filling = 1'b1;
  int          words_sent = 0;
  int          settings_written = 0;
  int          quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  circular_deque #(
    .SLOT_COUNT(16)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .capacity_we_i (capacity_we_i),
    .capacity_i    (capacity_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .empty_res_o   (empty_res_o),
    .full_res_o    (full_res_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o)
  );

  circular_deque_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .capacity_we_i     (capacity_we_i),
    .capacity_i        (capacity_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .value_i           (value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .ok_o              (ok_o),
    .empty_res_o       (empty_res_o),
    .full_res_o        (full_res_o),
    .front_value_o     (front_value_o),
    .rear_value_o      (rear_value_o),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding),
    .results_checked_o (results_checked)
  );

  // result side back-pressure, random plus the long hold-off
  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || capacity_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // offer one command word, with a random gap before it, and wait for acceptance
  task automatic send_word(logic [cd_pkg::CMD_W-1:0] cmd, logic [cd_pkg::WORD_W-1:0] word);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= word;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (cmd == cd_pkg::CMD_PUSH_FRONT || cmd == cd_pkg::CMD_PUSH_REAR) begin
      if (fill_level < cap_now) fill_level++;
    end else if (cmd == cd_pkg::CMD_POP_FRONT || cmd == cd_pkg::CMD_POP_REAR) begin
      if (fill_level > 0) fill_level--;
    end
  endtask

  // capacity changes only once the deque has drained all results
  task automatic write_capacity(int unsigned cap);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    capacity_we_i <= 1'b1;
    capacity_i    <= cap[cd_pkg::CAP_W-1:0];
    @(posedge clk_i);
    capacity_we_i <= 1'b0;
    cap_now    = cap;
    fill_level = 0;
    filling    = 1'b1;
    settings_written++;
  endtask

  // mostly fill-then-drain sweeps so full and empty are hit often
  task automatic pick_random_word(output logic [cd_pkg::CMD_W-1:0] cmd,
                                  output logic [cd_pkg::WORD_W-1:0] word);
    int unsigned roll;
    if (fill_level >= cap_now && $urandom_range(0, 9) < 8) filling = 1'b0;
    if (fill_level == 0 && $urandom_range(0, 9) < 8) filling = 1'b1;
    roll = $urandom_range(0, 99);
    if (roll < 5)
      cmd = cd_pkg::CMD_NOP + 3'($urandom_range(0, 3));
    else if ((roll < 75) == filling)
      cmd = $urandom_range(0, 1) ? cd_pkg::CMD_PUSH_FRONT : cd_pkg::CMD_PUSH_REAR;
    else
      cmd = $urandom_range(0, 1) ? cd_pkg::CMD_POP_FRONT : cd_pkg::CMD_POP_REAR;
    case ($urandom_range(0, 9))
      0:       word = '0;
      1:       word = '1;
      2:       word = 32'h8000_0000;
      3:       word = 32'h7FFF_FFFF;
      default: word = $urandom;
    endcase
  endtask

  initial begin
    logic [cd_pkg::CMD_W-1:0]  rand_cmd;
    logic [cd_pkg::WORD_W-1:0] rand_word;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: refused pops, spare codes, extreme values at full capacity
    send_word(cd_pkg::CMD_POP_FRONT, 32'h1234_5678);
    send_word(cd_pkg::CMD_POP_REAR, 32'h0);
    send_word(cd_pkg::CMD_NOP, 32'hDEAD_BEEF);
    send_word(cd_pkg::CMD_NOP + 3'd1, 32'h0);
    send_word(cd_pkg::CMD_NOP + 3'd2, 32'h0);
    send_word(cd_pkg::CMD_NOP + 3'd3, 32'hFFFF_FFFF);
    send_word(cd_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_word(cd_pkg::CMD_PUSH_REAR, 32'h7FFF_FFFF);
    send_word(cd_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
    send_word(cd_pkg::CMD_PUSH_REAR, 32'hFFFF_FFFF);
    send_word(cd_pkg::CMD_POP_FRONT, 32'h0);
    send_word(cd_pkg::CMD_POP_REAR, 32'h0);
    send_word(cd_pkg::CMD_POP_FRONT, 32'h0);
    send_word(cd_pkg::CMD_POP_REAR, 32'h0);

    // directed: single entry deque, refused pushes when full
    write_capacity(1);
    send_word(cd_pkg::CMD_PUSH_REAR, 32'h5A5A_5A5A);
    send_word(cd_pkg::CMD_PUSH_FRONT, 32'h1111_1111);
    send_word(cd_pkg::CMD_PUSH_REAR, 32'h2222_2222);
    send_word(cd_pkg::CMD_POP_FRONT, 32'h0);
    send_word(cd_pkg::CMD_POP_REAR, 32'h0);
    send_word(cd_pkg::CMD_PUSH_FRONT, 32'hA5A5_A5A5);
    send_word(cd_pkg::CMD_POP_REAR, 32'h0);

    // directed: capacity zero, always empty and full
    write_capacity(0);
    send_word(cd_pkg::CMD_PUSH_FRONT, 32'h3333_3333);
    send_word(cd_pkg::CMD_PUSH_REAR, 32'h4444_4444);
    send_word(cd_pkg::CMD_POP_FRONT, 32'h0);
    send_word(cd_pkg::CMD_POP_REAR, 32'h0);

    // random phases: capacity and idling mode change together
    for (int p = 0; p < 8; p++) begin
      case (p)
        0, 4, 7: write_capacity(15);
        1:       write_capacity(1);
        2:       write_capacity(3);
        3:       write_capacity(8);
        5:       write_capacity(2);
        default: write_capacity(5);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      // long output hold-off while words keep coming, input must back up
      if (p == 4) begin
        fork
          begin
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_on <= 1'b0;
          end
        join_none
      end
      repeat (PHASE_WORDS) begin
        pick_random_word(rand_cmd, rand_word);
        send_word(rand_cmd, rand_word);
      end
    end

    // drain and let the pipeline settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("summary: %0d command words sent, %0d result words checked, %0d mismatches",
             words_sent, results_checked, fail_count);
    $display("summary: %0d capacity settings incl. 0, 1 and 15, four idling modes, one hold-off",
             settings_written);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
